FILE: sv/mf3_pkg.sv
// Shared types, constants and helper functions of the 3x3 median filter.
package mf3_pkg;

	localparam int MAX_COLS   = 1024;
	localparam int COL_W      = $clog2(MAX_COLS);
	localparam int NCOL_W     = 11;
	localparam int ROW_W      = 16;
	localparam int PIX_W      = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;
	localparam int JOBQ_DEPTH = 4;
	localparam int JOBQ_PTR_W = $clog2(JOBQ_DEPTH);
	localparam int OUTQ_DEPTH = 8;
	localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);

	typedef enum logic {
		OP_PIXEL = 1'b0,
		OP_DRAIN = 1'b1
	} opcode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_NUM_ROWS = 1'b0,
		REG_NUM_COLS = 1'b1
	} cfg_reg_t;

	// LOAD primes the column window, SHIFT brings a new right column,
	// REPL replicates the right border column.
	typedef enum logic [1:0] {
		JOB_LOAD  = 2'd0,
		JOB_SHIFT = 2'd1,
		JOB_REPL  = 2'd2
	} job_kind_t;

	typedef logic [1:0] slot_t;

	typedef struct packed {
		job_kind_t        kind;
		logic             last;
		logic [PIX_W-1:0] top;
		logic [PIX_W-1:0] mid;
		logic [PIX_W-1:0] bot;
	} job_t;

	typedef struct packed {
		logic [PIX_W-1:0] median;
		logic             last;
		logic [PIX_W-1:0] min_v;
		logic [PIX_W-1:0] max_v;
	} result_t;

	// Row number modulo 3: base-4 digits all weigh one modulo 3.
	function automatic slot_t mod3(input logic [ROW_W-1:0] v);
		logic [4:0] s;
		logic [2:0] t;
		logic [2:0] u;
		s = '0;
		for (int i = 0; i < ROW_W / 2; i++) begin
			s = s + 5'(v[2*i +: 2]);
		end
		t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
		u = 3'(t[1:0]) + 3'(t[2]);
		return (u >= 3'd3) ? slot_t'(u - 3'd3) : slot_t'(u);
	endfunction

	function automatic slot_t slot_dec(input slot_t s);
		return (s == 2'd0) ? 2'd2 : slot_t'(s - 2'd1);
	endfunction

	// Compare-exchange: smaller value first.
	function automatic logic [2*PIX_W-1:0] ord(input logic [PIX_W-1:0] a,
		input logic [PIX_W-1:0] b);
		return (b < a) ? {b, a} : {a, b};
	endfunction

endpackage

FILE: sv/mf3_front.sv
// Front end: item intake, raster counters, line store and job issue.
module mf3_front import mf3_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [ROW_W-1:0]      num_rows,
	input  logic [NCOL_W-1:0]     num_cols,
	input  logic                  push,
	output logic                  full,
	input  logic                  opcode,
	input  logic [PIX_W-1:0]      pixel,
	input  logic [JOBQ_PTR_W:0]   jq_count,
	output logic                  jq_push,
	output job_t                  jq_din
);

	typedef struct packed {
		job_kind_t        kind;
		logic             last;
		logic [COL_W-1:0] col;
		slot_t            top;
		slot_t            mid;
		slot_t            bot;
		logic             byp;
	} iss_t;

	logic [NCOL_W-1:0] ec;
	logic [COL_W-1:0]  ec_m1;
	logic [ROW_W-1:0]  er;
	logic [ROW_W-1:0]  row_q;
	logic [COL_W-1:0]  col_q;
	logic [COL_W-1:0]  drain_q;
	logic [COL_W-1:0]  c_sel;
	logic [COL_W-1:0]  d_sel;
	logic              row_live;
	logic              accept;
	logic              space;
	logic              issue;
	logic              we;
	logic              j0_v;
	logic              need2;
	slot_t             sr, sr1, sr2, se, se1, se2;
	iss_t              j0, j1, is_d;
	iss_t              p1_q;
	logic              p1_v_q;
	iss_t              is_s1;
	logic              v_s1;
	logic [PIX_W-1:0]  px_s1;
	logic [PIX_W-1:0]  rd_s1 [3];

	always_comb begin
		if (num_cols == '0) begin
			ec = NCOL_W'(1);
		end else if (num_cols > NCOL_W'(MAX_COLS)) begin
			ec = NCOL_W'(MAX_COLS);
		end else begin
			ec = num_cols;
		end
		ec_m1    = COL_W'(ec - NCOL_W'(1));
		er       = (num_rows == '0) ? ROW_W'(1) : num_rows;
		row_live = row_q < er;
		c_sel    = (NCOL_W'(col_q) >= ec) ? ec_m1 : col_q;
		d_sel    = (NCOL_W'(drain_q) >= ec) ? ec_m1 : drain_q;
		sr       = mod3(row_q);
		sr1      = slot_dec(sr);
		sr2      = (row_q >= ROW_W'(2)) ? slot_dec(sr1) : slot_t'(0);
		se       = mod3(er);
		se1      = slot_dec(se);
		se2      = (er >= ROW_W'(2)) ? slot_dec(se1) : slot_t'(0);
		space    = ((JOBQ_PTR_W+2)'(jq_count) + (JOBQ_PTR_W+2)'(v_s1))
			< (JOBQ_PTR_W+2)'(JOBQ_DEPTH);
		full     = p1_v_q || !space;
		accept   = push && !full;
		we       = accept && (opcode == OP_PIXEL) && row_live;

		j0    = '0;
		j1    = '0;
		j0_v  = 1'b0;
		need2 = 1'b0;
		if (opcode == OP_PIXEL) begin
			if (row_live && row_q != '0) begin
				j0_v    = 1'b1;
				j0.kind = (c_sel == '0) ? JOB_LOAD : JOB_SHIFT;
				j0.col  = c_sel;
				j0.top  = sr2;
				j0.mid  = sr1;
				j0.bot  = sr;
				j0.byp  = 1'b1;
				need2   = (c_sel == ec_m1);
				j1.kind = JOB_REPL;
			end
		end else if (!row_live) begin
			j0_v   = 1'b1;
			j0.top = se2;
			j0.mid = se1;
			j0.bot = se1;
			j1.top = se2;
			j1.mid = se1;
			j1.bot = se1;
			if (d_sel == '0) begin
				// first drain primes column 0, then releases pixel 0
				j0.kind = JOB_LOAD;
				need2   = 1'b1;
				j1.kind = (ec_m1 != '0) ? JOB_SHIFT : JOB_REPL;
				j1.last = (ec_m1 == '0);
				j1.col  = COL_W'(1);
			end else begin
				j0.kind = (d_sel == ec_m1) ? JOB_REPL : JOB_SHIFT;
				j0.last = (d_sel == ec_m1);
				j0.col  = COL_W'(d_sel + COL_W'(1));
			end
		end

		if (p1_v_q) begin
			issue = space;
			is_d  = p1_q;
		end else begin
			issue = accept && j0_v;
			is_d  = j0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q   <= '0;
			col_q   <= '0;
			drain_q <= '0;
			p1_v_q  <= 1'b0;
			v_s1    <= 1'b0;
		end else begin
			v_s1 <= issue;
			if (p1_v_q && space) begin
				p1_v_q <= 1'b0;
			end
			if (accept) begin
				if (j0_v && need2) begin
					p1_v_q <= 1'b1;
				end
				if (opcode == OP_PIXEL) begin
					if (row_live) begin
						if (c_sel == ec_m1) begin
							col_q <= '0;
							row_q <= row_q + ROW_W'(1);
						end else begin
							col_q <= c_sel + COL_W'(1);
						end
					end
				end else if (!row_live) begin
					if (d_sel == ec_m1) begin
						// image complete: start over
						row_q   <= '0;
						col_q   <= '0;
						drain_q <= '0;
					end else begin
						drain_q <= d_sel + COL_W'(1);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && j0_v && need2) begin
			p1_q <= j1;
		end
		if (issue) begin
			is_s1 <= is_d;
			px_s1 <= pixel;
		end
	end

	// One bank per row slot; the row being written is taken from the bypass.
	for (genvar k = 0; k < 3; k++) begin : g_bank
		logic [PIX_W-1:0] bank [MAX_COLS];
		always_ff @(posedge clk) begin
			if (we && sr == slot_t'(k)) begin
				bank[c_sel] <= pixel;
			end
			if (issue) begin
				rd_s1[k] <= bank[is_d.col];
			end
		end
	end

	function automatic logic [PIX_W-1:0] pick(input slot_t s);
		case (s)
			2'd0:    return rd_s1[0];
			2'd1:    return rd_s1[1];
			default: return rd_s1[2];
		endcase
	endfunction

	always_comb begin
		jq_push     = v_s1;
		jq_din.kind = is_s1.kind;
		jq_din.last = is_s1.last;
		jq_din.top  = pick(is_s1.top);
		jq_din.mid  = pick(is_s1.mid);
		jq_din.bot  = is_s1.byp ? px_s1 : pick(is_s1.bot);
	end

endmodule

FILE: sv/mf3_jobq.sv
// Short job queue between the front end and the median back end.
module mf3_jobq import mf3_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  job_t                din,
	input  logic                pop,
	output job_t                dout,
	output logic [JOBQ_PTR_W:0] count,
	output logic                empty
);

	job_t                  mem_q [JOBQ_DEPTH];
	logic [JOBQ_PTR_W-1:0] wp_q;
	logic [JOBQ_PTR_W-1:0] rp_q;
	logic [JOBQ_PTR_W:0]   cnt_q;

	assign count = cnt_q;
	assign empty = (cnt_q == '0);
	assign dout  = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + JOBQ_PTR_W'(1);
			end
			if (pop) begin
				rp_q <= rp_q + JOBQ_PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + (JOBQ_PTR_W+1)'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - (JOBQ_PTR_W+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= din;
		end
	end

endmodule

FILE: sv/mf3_back.sv
// Back end: column window, median network, running min/max, result queue.
module mf3_back import mf3_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    jq_empty,
	input  job_t    jq_dout,
	output logic    jq_pop,
	input  logic    pop,
	output logic    empty,
	output result_t res
);

	typedef struct packed {
		logic [PIX_W-1:0] top;
		logic [PIX_W-1:0] mid;
		logic [PIX_W-1:0] bot;
	} col_t;

	col_t                  pr2_q, pr1_q, fresh, right;
	logic                  go;
	logic                  room;
	logic [PIX_W-1:0]      win [9];
	logic [PIX_W-1:0]      sa [9];
	logic [PIX_W-1:0]      sb [9];
	logic                  v_s1, v_s2, v_s3;
	logic                  last_s1, last_s2, last_s3;
	logic [PIX_W-1:0]      win_s1 [9];
	logic [PIX_W-1:0]      p_s2 [9];
	logic [PIX_W-1:0]      med_s3;
	logic [PIX_W-1:0]      min_q, max_q, nmin, nmax;
	result_t               oq_q [OUTQ_DEPTH];
	logic [OUTQ_PTR_W-1:0] wp_q, rp_q;
	logic [OUTQ_PTR_W:0]   ocnt_q;
	logic                  opop;

	always_comb begin
		room = ((OUTQ_PTR_W+2)'(ocnt_q) + (OUTQ_PTR_W+2)'(v_s1)
			+ (OUTQ_PTR_W+2)'(v_s2) + (OUTQ_PTR_W+2)'(v_s3))
			< (OUTQ_PTR_W+2)'(OUTQ_DEPTH);
		go     = !jq_empty && room;
		jq_pop = go;
		fresh  = '{top: jq_dout.top, mid: jq_dout.mid, bot: jq_dout.bot};
		right  = (jq_dout.kind == JOB_REPL) ? pr1_q : fresh;
		win[0] = pr2_q.top; win[1] = pr1_q.top; win[2] = right.top;
		win[3] = pr2_q.mid; win[4] = pr1_q.mid; win[5] = right.mid;
		win[6] = pr2_q.bot; win[7] = pr1_q.bot; win[8] = right.bot;
	end

	// First half of the nine-input median network: sort each row.
	always_comb begin
		sa = win_s1;
		{sa[1], sa[2]} = ord(sa[1], sa[2]);
		{sa[4], sa[5]} = ord(sa[4], sa[5]);
		{sa[7], sa[8]} = ord(sa[7], sa[8]);
		{sa[0], sa[1]} = ord(sa[0], sa[1]);
		{sa[3], sa[4]} = ord(sa[3], sa[4]);
		{sa[6], sa[7]} = ord(sa[6], sa[7]);
		{sa[1], sa[2]} = ord(sa[1], sa[2]);
		{sa[4], sa[5]} = ord(sa[4], sa[5]);
		{sa[7], sa[8]} = ord(sa[7], sa[8]);
	end

	// Second half: prune to the middle element.
	always_comb begin
		sb = p_s2;
		{sb[0], sb[3]} = ord(sb[0], sb[3]);
		{sb[5], sb[8]} = ord(sb[5], sb[8]);
		{sb[4], sb[7]} = ord(sb[4], sb[7]);
		{sb[3], sb[6]} = ord(sb[3], sb[6]);
		{sb[1], sb[4]} = ord(sb[1], sb[4]);
		{sb[2], sb[5]} = ord(sb[2], sb[5]);
		{sb[4], sb[7]} = ord(sb[4], sb[7]);
		{sb[4], sb[2]} = ord(sb[4], sb[2]);
		{sb[6], sb[4]} = ord(sb[6], sb[4]);
		{sb[4], sb[2]} = ord(sb[4], sb[2]);
	end

	always_comb begin
		nmin  = (med_s3 < min_q) ? med_s3 : min_q;
		nmax  = (med_s3 > max_q) ? med_s3 : max_q;
		empty = (ocnt_q == '0);
		opop  = pop && !empty;
		res   = oq_q[rp_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			min_q  <= '1;
			max_q  <= '0;
			wp_q   <= '0;
			rp_q   <= '0;
			ocnt_q <= '0;
		end else begin
			v_s1 <= go && (jq_dout.kind != JOB_LOAD);
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (v_s3) begin
				wp_q <= wp_q + OUTQ_PTR_W'(1);
				if (last_s3) begin
					// end of image: restart the running extremes
					min_q <= '1;
					max_q <= '0;
				end else begin
					min_q <= nmin;
					max_q <= nmax;
				end
			end
			if (opop) begin
				rp_q <= rp_q + OUTQ_PTR_W'(1);
			end
			if (v_s3 && !opop) begin
				ocnt_q <= ocnt_q + (OUTQ_PTR_W+1)'(1);
			end else if (opop && !v_s3) begin
				ocnt_q <= ocnt_q - (OUTQ_PTR_W+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			case (jq_dout.kind)
				JOB_LOAD: begin
					pr2_q <= fresh;
					pr1_q <= fresh;
				end
				JOB_SHIFT: begin
					pr2_q <= pr1_q;
					pr1_q <= fresh;
				end
				default: begin
				end
			endcase
			win_s1  <= win;
			last_s1 <= jq_dout.last;
		end
		p_s2    <= sa;
		last_s2 <= last_s1;
		med_s3  <= sb[4];
		last_s3 <= last_s2;
		if (v_s3) begin
			oq_q[wp_q] <= '{median: med_s3, last: last_s3, min_v: nmin, max_v: nmax};
		end
	end

endmodule

FILE: sv/median3x3_image_filter_unit.sv
// Path: issue register, job queue, window and sort registers, result queue. Throughput: one
// item per cycle while full is low; a row-end pixel and the first drain item issue two jobs,
// as the single read port feeds one window column per cycle; full stays high meanwhile.
// Reset: counters cleared, num_rows and num_cols set to one, running min 65535 and max 0;
// the line store is not cleared.
module median3x3_image_filter_unit import mf3_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  logic                  opcode,
	input  logic [PIX_W-1:0]      pixel,
	output logic                  empty,
	input  logic                  pop,
	output logic [PIX_W-1:0]      median,
	output logic                  last,
	output logic [PIX_W-1:0]      min_so_far,
	output logic [PIX_W-1:0]      max_so_far,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [ROW_W-1:0]    num_rows_q;
	logic [NCOL_W-1:0]   num_cols_q;
	logic                jq_push, jq_pop, jq_empty;
	job_t                jq_din, jq_dout;
	logic [JOBQ_PTR_W:0] jq_count;
	result_t             res;

	assign cfg_ready  = 1'b1;
	assign median     = res.median;
	assign last       = res.last;
	assign min_so_far = res.min_v;
	assign max_so_far = res.max_v;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_rows_q <= ROW_W'(1);
			num_cols_q <= NCOL_W'(1);
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_NUM_ROWS: num_rows_q <= cfg_data[ROW_W-1:0];
				REG_NUM_COLS: num_cols_q <= cfg_data[NCOL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	mf3_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.num_rows (num_rows_q),
		.num_cols (num_cols_q),
		.push     (push),
		.full     (full),
		.opcode   (opcode),
		.pixel    (pixel),
		.jq_count (jq_count),
		.jq_push  (jq_push),
		.jq_din   (jq_din)
	);

	mf3_jobq u_jobq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (jq_push),
		.din    (jq_din),
		.pop    (jq_pop),
		.dout   (jq_dout),
		.count  (jq_count),
		.empty  (jq_empty)
	);

	mf3_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.jq_empty (jq_empty),
		.jq_dout  (jq_dout),
		.jq_pop   (jq_pop),
		.pop      (pop),
		.empty    (empty),
		.res      (res)
	);

endmodule
